### hw/rtl/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants of the script tokenizer
// Payload structs, result kinds, action codes, scan modes and the
// character codes that the lexer looks for.
// ----------------------------------------------------------------------------
package stk_pkg;

   // input actions
   localparam logic [1:0] ACT_BYTE   = 2'd0;
   localparam logic [1:0] ACT_REWIND = 2'd1;
   localparam logic [1:0] ACT_SKIP   = 2'd2;

   // character codes
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;

   // CSR map
   localparam logic REG_CROSS_LINE = 1'b0;

   // queue between lexer and output stage
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      KIND_CHAR    = 3'd0,
      KIND_END     = 3'd1,
      KIND_NOLINE  = 3'd2,
      KIND_LONG    = 3'd3,
      KIND_CROSSED = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      MODE_SKIP     = 3'd0,
      MODE_PLAIN    = 3'd1,
      MODE_QUOTE    = 3'd2,
      MODE_LCOMMENT = 3'd3,
      MODE_BCOMMENT = 3'd4,
      MODE_DPLAIN   = 3'd5,
      MODE_DQUOTE   = 3'd6,
      MODE_SKIPLINE = 3'd7
   } mode_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] text_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  token_char;
      logic        has_char;
      logic [15:0] line_number;
      logic        last_of_step;
   } rsp_type;

   // one queued word: one or two results of a single input word
   typedef struct packed {
      logic    pair;
      rsp_type first;
      rsp_type second;
   } entry_type;

   function automatic logic is_sep(input logic [7:0] b);
      return (b <= CH_SPACE) || (b == CH_SEMI) || (b == CH_COMMA);
   endfunction

endpackage

### hw/rtl/script_tokenizer_core.sv
// Each result passes through the result queue and then the output register.
// Throughput: one input word per cycle while the result queue has room; the
// output register sends one result per cycle while rsp_ready is high, so
// the four-word result queue absorbs words that yield two results.
// Reset: synchronous, clears scan state, line count and queue; cross_line = 1.
// ----------------------------------------------------------------------------
// script_tokenizer_core: streaming script lexer
// Lexer front end, result queue and output stage, plus the CSR port.
// ----------------------------------------------------------------------------
module script_tokenizer_core #(
   parameter int MAX_TOKEN_LEN = 256,
   parameter int LINE_WIDTH    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stk_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stk_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import stk_pkg::*;

   logic      cross_ff;
   logic      q_full;
   logic      q_push;
   entry_type q_entry;
   logic      head_valid;
   entry_type head_entry;
   logic      pop;

   // CSR port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_CROSS_LINE) ? {31'd0, cross_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cross_ff <= 1'b1;
      end else if (psel && penable && pwrite && paddr[2] == REG_CROSS_LINE) begin
         cross_ff <= pwdata[0];
      end
   end

   stk_front #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
      .LINE_WIDTH   (LINE_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cross_line(cross_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   stk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_entry(q_entry),
      .full      (q_full),
      .head_valid(head_valid),
      .head_entry(head_entry),
      .pop       (pop)
   );

   stk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_entry(head_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/stk_front.sv
// ----------------------------------------------------------------------------
// stk_front: lexer front end
// Takes one input word per cycle while the queue is not full, updates the
// scan state and queues the results, none, one or two, that the word causes.
// ----------------------------------------------------------------------------
module stk_front #(
   parameter int MAX_TOKEN_LEN = 256,
   parameter int LINE_WIDTH    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  stk_pkg::req_type   req_data,
   input  logic               cross_line,
   input  logic               q_full,
   output logic               q_push,
   output stk_pkg::entry_type q_entry
);
   import stk_pkg::*;

   localparam int LC_W = (LINE_WIDTH < 16) ? LINE_WIDTH : 16;
   localparam int TC_W = $clog2(MAX_TOKEN_LEN);
   localparam logic [TC_W-1:0] TC_LAST = TC_W'(MAX_TOKEN_LEN - 1);

   mode_type        mode_ff, mode_in;
   logic            slash_ff, slash_in;
   logic            paren_ff, paren_in;
   logic            star_ff, star_in;
   logic            cerr_ff, cerr_in;
   logic [TC_W-1:0] tc_ff, tc_in;
   logic [LC_W-1:0] lc_ff, lc_in;

   rsp_type         res [2];
   logic [1:0]      n_res;
   logic            accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && !q_full;

   // scan step
   always_comb begin
      logic [7:0] b;
      logic       eob;
      logic       sep;
      logic       nl;
      logic [7:0] closer;
      logic       do_plain;
      logic       do_append;
      mode_type   disc;

      b         = req_data.text_byte;
      eob       = req_data.end_of_buffer;
      sep       = is_sep(b);
      nl        = (b == CH_NL);
      closer    = paren_ff ? CH_RPAREN : CH_QUOTE;
      do_plain  = 1'b0;
      do_append = 1'b0;
      disc      = MODE_DPLAIN;

      mode_in  = mode_ff;
      slash_in = slash_ff;
      paren_in = paren_ff;
      star_in  = star_ff;
      cerr_in  = cerr_ff;
      tc_in    = tc_ff;
      lc_in    = lc_ff;
      n_res    = 2'd0;
      res[0]   = '0;
      res[1]   = '0;

      unique case (req_data.action)
         ACT_BYTE: begin
            unique case (mode_ff)
               MODE_SKIP: begin
                  if (slash_ff) begin
                     slash_in = 1'b0;
                     if (b == CH_SLASH) begin
                        mode_in = MODE_LCOMMENT;
                     end else if (b == CH_STAR) begin
                        mode_in = MODE_BCOMMENT;
                        star_in = 1'b0;
                        cerr_in = 1'b0;
                     end else begin
                        // lone slash becomes the first token char
                        mode_in = MODE_PLAIN;
                        tc_in   = TC_W'(1);
                        res[n_res[0]] = '{KIND_CHAR, CH_SLASH, 1'b1, 16'(lc_in), 1'b0};
                        n_res   = n_res + 2'd1;
                        do_plain = 1'b1;
                     end
                  end else if (sep) begin
                     if (nl) begin
                        if (lc_in != '1) lc_in = lc_in + 1'b1;
                        if (!cross_line) begin
                           res[n_res[0]] = '{KIND_NOLINE, 8'd0, 1'b0, 16'(lc_in), 1'b0};
                           n_res = n_res + 2'd1;
                        end
                     end
                  end else if (b == CH_SLASH) begin
                     if (eob) begin
                        res[n_res[0]] = '{KIND_END, CH_SLASH, 1'b1, 16'(lc_in), 1'b0};
                        n_res = n_res + 2'd1;
                     end else begin
                        slash_in = 1'b1;
                     end
                  end else if (b == CH_QUOTE || b == CH_LPAREN) begin
                     mode_in  = MODE_QUOTE;
                     paren_in = (b == CH_LPAREN);
                     tc_in    = '0;
                     if (eob) begin
                        res[n_res[0]] = '{KIND_END, 8'd0, 1'b0, 16'(lc_in), 1'b0};
                        n_res = n_res + 2'd1;
                     end
                  end else begin
                     mode_in  = MODE_PLAIN;
                     tc_in    = '0;
                     do_plain = 1'b1;
                  end
               end
               MODE_PLAIN: begin
                  do_plain = 1'b1;
               end
               MODE_QUOTE: begin
                  if (b == closer) begin
                     res[n_res[0]] = '{KIND_END, 8'd0, 1'b0, 16'(lc_in), 1'b0};
                     n_res   = n_res + 2'd1;
                     mode_in = MODE_SKIP;
                  end else begin
                     do_append = 1'b1;
                     disc      = MODE_DQUOTE;
                  end
               end
               MODE_LCOMMENT: begin
                  if (nl) begin
                     if (lc_in != '1) lc_in = lc_in + 1'b1;
                     mode_in = MODE_SKIP;
                     if (!cross_line) begin
                        res[n_res[0]] = '{KIND_NOLINE, 8'd0, 1'b0, 16'(lc_in), 1'b0};
                        n_res = n_res + 2'd1;
                     end
                  end
               end
               MODE_BCOMMENT: begin
                  if (star_ff && b == CH_SLASH) begin
                     mode_in = MODE_SKIP;
                     star_in = 1'b0;
                     if (cerr_ff) begin
                        res[n_res[0]] = '{KIND_CROSSED, 8'd0, 1'b0, 16'(lc_in), 1'b0};
                        n_res = n_res + 2'd1;
                     end
                     cerr_in = 1'b0;
                  end else begin
                     star_in = (b == CH_STAR);
                     if (nl) begin
                        if (lc_in != '1) lc_in = lc_in + 1'b1;
                        if (!cross_line) cerr_in = 1'b1;
                     end
                  end
               end
               MODE_DPLAIN: begin
                  if (sep) begin
                     if (nl && lc_in != '1) lc_in = lc_in + 1'b1;
                     mode_in = MODE_SKIP;
                  end
               end
               MODE_DQUOTE: begin
                  if (b == closer) mode_in = MODE_SKIP;
               end
               MODE_SKIPLINE: begin
                  if (nl) begin
                     if (lc_in != '1) lc_in = lc_in + 1'b1;
                     mode_in = MODE_SKIP;
                  end else if (eob) begin
                     if (lc_in != '1) lc_in = lc_in + 1'b1;
                  end
               end
            endcase

            // plain token byte: separator ends it, else append
            if (do_plain) begin
               if (sep) begin
                  if (nl && lc_in != '1) lc_in = lc_in + 1'b1;
                  res[n_res[0]] = '{KIND_END, 8'd0, 1'b0, 16'(lc_in), 1'b0};
                  n_res   = n_res + 2'd1;
                  mode_in = MODE_SKIP;
               end else begin
                  do_append = 1'b1;
                  disc      = MODE_DPLAIN;
               end
            end

            // append with length check
            if (do_append) begin
               if (tc_in >= TC_LAST) begin
                  res[n_res[0]] = '{KIND_LONG, 8'd0, 1'b0, 16'(lc_in), 1'b0};
                  n_res   = n_res + 2'd1;
                  mode_in = disc;
               end else begin
                  tc_in = tc_in + 1'b1;
                  res[n_res[0]] = '{(eob ? KIND_END : KIND_CHAR), b, 1'b1, 16'(lc_in), 1'b0};
                  n_res = n_res + 2'd1;
                  if (eob) mode_in = MODE_SKIP;
               end
            end

            // end of buffer closes everything
            if (eob) begin
               mode_in  = MODE_SKIP;
               slash_in = 1'b0;
               star_in  = 1'b0;
               cerr_in  = 1'b0;
               tc_in    = '0;
            end
         end
         ACT_REWIND: begin
            mode_in  = MODE_SKIP;
            slash_in = 1'b0;
            paren_in = 1'b0;
            star_in  = 1'b0;
            cerr_in  = 1'b0;
            tc_in    = '0;
            lc_in    = '0;
         end
         ACT_SKIP: begin
            if (slash_ff) begin
               res[0] = '{KIND_END, CH_SLASH, 1'b1, 16'(lc_ff), 1'b0};
               n_res  = 2'd1;
            end else if (mode_ff == MODE_PLAIN || mode_ff == MODE_QUOTE) begin
               res[0] = '{KIND_END, 8'd0, 1'b0, 16'(lc_ff), 1'b0};
               n_res  = 2'd1;
            end
            mode_in  = MODE_SKIPLINE;
            slash_in = 1'b0;
            star_in  = 1'b0;
            cerr_in  = 1'b0;
            tc_in    = '0;
         end
         default: begin
            // unused action: no effect
         end
      endcase
   end

   // queue word
   always_comb begin
      q_push                = accept && (n_res != 2'd0);
      q_entry.pair          = n_res[1];
      q_entry.first         = res[0];
      q_entry.second        = res[1];
      q_entry.first.last_of_step  = !n_res[1];
      q_entry.second.last_of_step = 1'b1;
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SKIP;
         slash_ff <= 1'b0;
         paren_ff <= 1'b0;
         star_ff  <= 1'b0;
         cerr_ff  <= 1'b0;
         tc_ff    <= '0;
         lc_ff    <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         slash_ff <= slash_in;
         paren_ff <= paren_in;
         star_ff  <= star_in;
         cerr_ff  <= cerr_in;
         tc_ff    <= tc_in;
         lc_ff    <= lc_in;
      end
   end

endmodule

### hw/rtl/stk_queue.sv
// ----------------------------------------------------------------------------
// stk_queue: result queue
// Small register FIFO that holds result words between lexer and output.
// ----------------------------------------------------------------------------
module stk_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  stk_pkg::entry_type push_entry,
   output logic               full,
   output logic               head_valid,
   output stk_pkg::entry_type head_entry,
   input  logic               pop
);
   import stk_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_entry = mem_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_entry;
   end

endmodule

### hw/rtl/stk_back.sv
// ----------------------------------------------------------------------------
// stk_back: result output stage
// Splits each queued word into its results and drives them through an
// output register, one result per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module stk_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  stk_pkg::entry_type head_entry,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output stk_pkg::rsp_type   rsp_data
);
   import stk_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic    sel_ff, sel_in;
   logic    load;

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   // load when the output register is free or being taken
   always_comb begin
      load     = head_valid && (!valid_ff || rsp_ready);
      valid_in = valid_ff;
      data_in  = data_ff;
      sel_in   = sel_ff;
      pop      = 1'b0;
      if (valid_ff && rsp_ready) valid_in = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         data_in  = sel_ff ? head_entry.second : head_entry.first;
         if (sel_ff || !head_entry.pair) begin
            pop    = 1'b1;
            sel_in = 1'b0;
         end else begin
            sel_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

### hw/rtl/stk_checker.sv
// ----------------------------------------------------------------------------
// stk_checker: port-level checks of the script tokenizer
// Watches the result channel and checks handshake and result encoding.
// ----------------------------------------------------------------------------
module stk_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input stk_pkg::rsp_type rsp_data
);
   import stk_pkg::*;

   // stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // token char field is zero without a char
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_char |-> rsp_data.token_char == 8'd0)
      else $error("token_char set without has_char");

   // a token char result always carries its byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_CHAR |-> rsp_data.has_char)
      else $error("token char without byte");

   // status results carry no byte and close their word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == KIND_NOLINE || rsp_data.kind == KIND_LONG ||
                    rsp_data.kind == KIND_CROSSED)
      |-> !rsp_data.has_char && rsp_data.last_of_step)
      else $error("bad status result");

endmodule

bind script_tokenizer_core stk_checker u_stk_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

### tb/sv/script_tokenizer_core_tb.sv
// ----------------------------------------------------------------------------
// script_tokenizer_core_tb: self-checking bench for the script lexer
// Drives script words through the req channel and predicts every rsp word
// with a behavioral lexer kept inside the bench. Each rsp word is compared
// field by field with the oldest prediction. The run goes through directed
// cases, overlong tokens, a long receiver hold-off, random script fragments
// under both cross_line settings and a tail with no idling on either side.
// ----------------------------------------------------------------------------
module script_tokenizer_core_tb;
   import stk_pkg::*;

   localparam int          MAX_LEN  = 256;
   localparam int          LINE_W   = 16;
   localparam logic [15:0] LINE_MAX = (LINE_W < 16) ? 16'((1 << LINE_W) - 1) : 16'hFFFF;
   // action code that the lexer ignores
   localparam logic [1:0]  ACT_NONE = 2'd3;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // bench control
   logic        send_idle;
   logic        stall_en;
   int          hold_len;
   int          fail_count;
   int          words_sent;

   // lexer prediction state
   logic        cross_model;
   mode_type    lex_mode;
   logic        held_slash;
   logic        paren_close;
   logic        star_prev;
   logic        crossed_nl;
   int          tok_len;
   logic [15:0] line_cnt;
   rsp_type     word_results[$];
   rsp_type     expected_results[$];
   rsp_type     head_result;

   script_tokenizer_core #(
      .MAX_TOKEN_LEN(MAX_LEN),
      .LINE_WIDTH   (LINE_W)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // clock, period 10
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------------
   // Lexer prediction
   // ------------------------------------------------------------------------
   function automatic logic separator(logic [7:0] b);
      return (b <= CH_SPACE) || (b == CH_SEMI) || (b == CH_COMMA);
   endfunction

   function automatic void add_result(kind_type k, logic [7:0] ch, logic has);
      rsp_type r;
      r.kind         = k;
      r.token_char   = has ? ch : 8'h00;
      r.has_char     = has;
      r.line_number  = line_cnt;
      r.last_of_step = 1'b0;
      word_results.push_back(r);
   endfunction

   function automatic void count_newline();
      if (line_cnt < LINE_MAX) line_cnt++;
   endfunction

   function automatic void clear_lexer();
      lex_mode    = MODE_SKIP;
      held_slash  = 1'b0;
      paren_close = 1'b0;
      star_prev   = 1'b0;
      crossed_nl  = 1'b0;
      tok_len     = 0;
      line_cnt    = '0;
   endfunction

   // one more token byte; overflow flags the token and drops the rest
   function automatic void add_token_byte(logic [7:0] b, logic eob, mode_type drop_mode);
      if (tok_len >= MAX_LEN - 1) begin
         add_result(KIND_LONG, 8'h00, 1'b0);
         lex_mode = drop_mode;
         return;
      end
      tok_len++;
      add_result(eob ? KIND_END : KIND_CHAR, b, 1'b1);
      if (eob) lex_mode = MODE_SKIP;
   endfunction

   function automatic void plain_char(logic [7:0] b, logic eob);
      if (separator(b)) begin
         if (b == CH_NL) count_newline();
         add_result(KIND_END, 8'h00, 1'b0);
         lex_mode = MODE_SKIP;
      end else begin
         add_token_byte(b, eob, MODE_DPLAIN);
      end
   endfunction

   // searching for a token, with the one-byte slash hold-back
   function automatic void skip_char(logic [7:0] b, logic eob);
      if (held_slash) begin
         held_slash = 1'b0;
         if (b == CH_SLASH) begin
            lex_mode = MODE_LCOMMENT;
         end else if (b == CH_STAR) begin
            lex_mode   = MODE_BCOMMENT;
            star_prev  = 1'b0;
            crossed_nl = 1'b0;
         end else begin
            lex_mode = MODE_PLAIN;
            tok_len  = 1;
            add_result(KIND_CHAR, CH_SLASH, 1'b1);
            plain_char(b, eob);
         end
         return;
      end
      if (separator(b)) begin
         if (b == CH_NL) begin
            count_newline();
            if (!cross_model) add_result(KIND_NOLINE, 8'h00, 1'b0);
         end
      end else if (b == CH_SLASH) begin
         if (eob) add_result(KIND_END, CH_SLASH, 1'b1);
         else held_slash = 1'b1;
      end else if (b == CH_QUOTE || b == CH_LPAREN) begin
         lex_mode    = MODE_QUOTE;
         paren_close = (b == CH_LPAREN);
         tok_len     = 0;
         if (eob) add_result(KIND_END, 8'h00, 1'b0);
      end else begin
         lex_mode = MODE_PLAIN;
         tok_len  = 0;
         plain_char(b, eob);
      end
   endfunction

   function automatic void lex_byte(logic [7:0] b, logic eob);
      logic [7:0] closer;
      closer = paren_close ? CH_RPAREN : CH_QUOTE;
      case (lex_mode)
         MODE_SKIP: skip_char(b, eob);
         MODE_PLAIN: plain_char(b, eob);
         MODE_QUOTE: begin
            if (b == closer) begin
               add_result(KIND_END, 8'h00, 1'b0);
               lex_mode = MODE_SKIP;
            end else begin
               add_token_byte(b, eob, MODE_DQUOTE);
            end
         end
         MODE_LCOMMENT: begin
            if (b == CH_NL) begin
               count_newline();
               lex_mode = MODE_SKIP;
               if (!cross_model) add_result(KIND_NOLINE, 8'h00, 1'b0);
            end
         end
         MODE_BCOMMENT: begin
            if (star_prev && b == CH_SLASH) begin
               lex_mode  = MODE_SKIP;
               star_prev = 1'b0;
               if (crossed_nl) add_result(KIND_CROSSED, 8'h00, 1'b0);
               crossed_nl = 1'b0;
            end else begin
               star_prev = (b == CH_STAR);
               if (b == CH_NL) begin
                  count_newline();
                  if (!cross_model) crossed_nl = 1'b1;
               end
            end
         end
         MODE_DPLAIN: begin
            if (separator(b)) begin
               if (b == CH_NL) count_newline();
               lex_mode = MODE_SKIP;
            end
         end
         MODE_DQUOTE: begin
            if (b == closer) lex_mode = MODE_SKIP;
         end
         default: begin
            // skip line: a final byte that is not a newline still ends the line
            if (b == CH_NL) begin
               count_newline();
               lex_mode = MODE_SKIP;
            end else if (eob) begin
               count_newline();
            end
         end
      endcase
      if (eob) begin
         lex_mode   = MODE_SKIP;
         held_slash = 1'b0;
         star_prev  = 1'b0;
         crossed_nl = 1'b0;
         tok_len    = 0;
      end
   endfunction

   // predicts the rsp words of one accepted req word
   function automatic void predict_word(req_type w);
      rsp_type r;
      word_results.delete();
      case (w.action)
         ACT_BYTE: lex_byte(w.text_byte, w.end_of_buffer);
         ACT_REWIND: begin
            clear_lexer();
         end
         ACT_SKIP: begin
            if (held_slash) add_result(KIND_END, CH_SLASH, 1'b1);
            else if (lex_mode == MODE_PLAIN || lex_mode == MODE_QUOTE)
               add_result(KIND_END, 8'h00, 1'b0);
            lex_mode   = MODE_SKIPLINE;
            held_slash = 1'b0;
            star_prev  = 1'b0;
            crossed_nl = 1'b0;
            tok_len    = 0;
         end
         default: begin
         end
      endcase
      if (word_results.size() > 0) begin
         r = word_results.pop_back();
         r.last_of_step = 1'b1;
         word_results.push_back(r);
      end
      foreach (word_results[i]) expected_results.push_back(word_results[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected rsp word: expected none, actual kind %0d char %0d",
                     $time, rsp_data.kind, rsp_data.token_char);
            fail_count++;
         end else begin
            head_result = expected_results.pop_front();
            check_field("kind", head_result.kind, rsp_data.kind);
            check_field("token_char", head_result.token_char, rsp_data.token_char);
            check_field("has_char", head_result.has_char, rsp_data.has_char);
            check_field("line_number", head_result.line_number, rsp_data.line_number);
            check_field("last_of_step", head_result.last_of_step, rsp_data.last_of_step);
         end
      end
   end

   // receiver: random stall bursts, or a long hold-off when requested
   always begin
      @(posedge clock);
      if (hold_len > 0) begin
         rsp_ready <= 1'b0;
         repeat (hold_len) @(posedge clock);
         hold_len = 0;
         rsp_ready <= 1'b1;
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Sender and CSR access
   // ------------------------------------------------------------------------
   // offer one word, hold it until accepted, then predict it
   task automatic send_word(req_type w);
      if (send_idle && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      predict_word(w);
      words_sent++;
   endtask

   task automatic send_byte(logic [7:0] b, logic eob);
      send_word('{action: ACT_BYTE, text_byte: b, end_of_buffer: eob});
   endtask

   // non-byte actions carry random filler in the other fields
   task automatic send_action(logic [1:0] act);
      send_word('{action: act, text_byte: 8'($urandom()), end_of_buffer: 1'($urandom())});
   endtask

   // drop valid and wait until the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // write cross_line while idle, then read it back
   task automatic csr_write(logic [31:0] data);
      settle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(REG_CROSS_LINE) << 2;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      cross_model = data[0];
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      psel    <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field("cross_line readback", {31'b0, cross_model}, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Random script text
   // ------------------------------------------------------------------------
   function automatic logic [7:0] token_char();
      logic [7:0] c;
      do begin
         c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255))
                                         : 8'($urandom_range(33, 126));
      end while (c == CH_SEMI || c == CH_COMMA || c == CH_SLASH ||
                 c == CH_QUOTE || c == CH_LPAREN);
      return c;
   endfunction

   function automatic logic [7:0] sep_char();
      case ($urandom_range(0, 5))
         0: return CH_NL;
         1: return CH_SEMI;
         2: return CH_COMMA;
         3: return CH_SPACE;
         default: return 8'($urandom_range(0, 32));
      endcase
   endfunction

   function automatic logic [7:0] quoted_char(logic [7:0] closer);
      logic [7:0] c;
      do c = 8'($urandom()); while (c == closer);
      return c;
   endfunction

   // one fragment of script: mostly well-formed, some noise
   task automatic send_fragment();
      int         pick;
      int         n;
      logic [7:0] open_ch;
      logic [7:0] close_ch;
      logic [7:0] c;
      pick = $urandom_range(0, 99);
      n    = $urandom_range(0, 6);
      if ($urandom_range(0, 149) == 0) begin
         // token near or past the length limit
         repeat ($urandom_range(250, 270)) send_byte(token_char(), 1'b0);
         send_byte(sep_char(), 1'b0);
      end else if (pick < 28) begin
         repeat (n + 1) send_byte(token_char(), 1'b0);
         send_byte(sep_char(), 1'b0);
      end else if (pick < 38) begin
         open_ch  = $urandom_range(0, 1) ? CH_QUOTE : CH_LPAREN;
         close_ch = (open_ch == CH_QUOTE) ? CH_QUOTE : CH_RPAREN;
         send_byte(open_ch, 1'b0);
         repeat (n) send_byte($urandom_range(0, 3) == 0 ? sep_char() : quoted_char(close_ch),
                              1'b0);
         send_byte(close_ch, 1'b0);
      end else if (pick < 45) begin
         send_byte(CH_SLASH, 1'b0);
         send_byte(CH_SLASH, 1'b0);
         repeat (n) begin
            c = quoted_char(CH_NL);
            send_byte(c, 1'b0);
         end
         send_byte(CH_NL, 1'b0);
      end else if (pick < 53) begin
         send_byte(CH_SLASH, 1'b0);
         send_byte(CH_STAR, 1'b0);
         repeat (n) begin
            case ($urandom_range(0, 3))
               0: c = CH_STAR;
               1: c = CH_NL;
               2: c = CH_SLASH;
               default: c = token_char();
            endcase
            send_byte(c, 1'b0);
         end
         send_byte(CH_STAR, 1'b0);
         send_byte(CH_SLASH, 1'b0);
      end else if (pick < 58) begin
         // lone slash, then a token byte, a separator or the final byte
         send_byte(CH_SLASH, $urandom_range(0, 4) == 0);
         send_byte($urandom_range(0, 1) ? token_char() : sep_char(), 1'b0);
      end else if (pick < 66) begin
         case ($urandom_range(0, 2))
            0: send_byte(token_char(), 1'b0);
            1: send_byte(CH_SLASH, 1'b0);
            default: send_byte($urandom_range(0, 1) ? CH_QUOTE : CH_LPAREN, 1'b0);
         endcase
         send_action(ACT_SKIP);
         repeat (n) send_byte(quoted_char(CH_NL), 1'b0);
         send_byte($urandom_range(0, 3) == 0 ? token_char() : CH_NL, $urandom_range(0, 3) == 0);
      end else if (pick < 74) begin
         repeat (n + 1) send_byte(sep_char(), 1'b0);
      end else if (pick < 82) begin
         repeat (n) send_byte(token_char(), 1'b0);
         send_byte($urandom_range(0, 1) ? token_char() : 8'($urandom()), 1'b1);
      end else if (pick < 97) begin
         // noise: any action, any byte
         repeat (n + 1) begin
            send_word('{action: ($urandom_range(0, 3) == 0) ? 2'($urandom()) : ACT_BYTE,
                        text_byte: 8'($urandom()),
                        end_of_buffer: $urandom_range(0, 9) == 0});
         end
      end else begin
         send_action(ACT_REWIND);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // separators, quotes, parens, comments, lone slash, final byte, actions
   task automatic test_directed();
      send_byte("A", 1'b0);
      send_byte(CH_COMMA, 1'b0);
      send_byte(CH_SLASH, 1'b0);
      send_byte("x", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(CH_QUOTE, 1'b0);
      send_byte(CH_NL, 1'b0);
      send_byte(CH_QUOTE, 1'b0);
      send_byte(CH_LPAREN, 1'b0);
      send_byte(CH_RPAREN, 1'b0);
      send_byte(CH_SLASH, 1'b0);
      send_byte(CH_SLASH, 1'b0);
      send_byte("z", 1'b0);
      send_byte(CH_NL, 1'b0);
      send_byte(CH_SLASH, 1'b0);
      send_byte(CH_STAR, 1'b0);
      send_byte(CH_STAR, 1'b0);
      send_byte(CH_SLASH, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte("k", 1'b0);
      send_action(ACT_SKIP);
      send_byte("m", 1'b0);
      send_byte(CH_NL, 1'b0);
      send_byte(CH_SLASH, 1'b0);
      send_action(ACT_SKIP);
      send_byte(CH_SLASH, 1'b1);
      send_action(ACT_NONE);
      send_action(ACT_REWIND);
   endtask

   // newline reporting with cross_line cleared
   task automatic test_cross_line();
      csr_write(32'hFFFF_FFFE);
      send_byte(CH_NL, 1'b0);
      send_byte("t", 1'b0);
      send_byte(CH_NL, 1'b0);
      send_byte(CH_SLASH, 1'b0);
      send_byte(CH_SLASH, 1'b0);
      send_byte(CH_NL, 1'b0);
      send_byte(CH_SLASH, 1'b0);
      send_byte(CH_STAR, 1'b0);
      send_byte(CH_NL, 1'b0);
      send_byte(CH_STAR, 1'b0);
      send_byte(CH_SLASH, 1'b0);
      // unclosed comment at the final byte reports nothing
      send_byte(CH_SLASH, 1'b0);
      send_byte(CH_STAR, 1'b0);
      send_byte(CH_NL, 1'b0);
      send_byte("q", 1'b1);
      send_action(ACT_SKIP);
      send_byte("r", 1'b1);
      send_byte(CH_LPAREN, 1'b1);
      csr_write(32'h0000_0001);
   endtask

   // tokens past the length limit, plain and in parens
   task automatic test_long_tokens();
      repeat (MAX_LEN + 1) send_byte(token_char(), 1'b0);
      send_byte(CH_NL, 1'b0);
      send_byte(CH_LPAREN, 1'b0);
      repeat (MAX_LEN) send_byte(quoted_char(CH_RPAREN), 1'b0);
      send_byte(CH_RPAREN, 1'b0);
      send_action(ACT_REWIND);
   endtask

   // receiver holds off while the sender keeps offering slash-led tokens, some words yielding two results
   task automatic test_backpressure();
      settle();
      hold_len = 400;
      repeat (20) begin
         send_byte(CH_SLASH, 1'b0);
         send_byte(token_char(), 1'b0);
         send_byte(CH_SEMI, 1'b0);
      end
   endtask

   // random fragments, alternating cross_line between phases
   task automatic test_random();
      int target;
      for (int ph = 0; ph < 4; ph++) begin
         csr_write({31'($urandom()), 1'(ph % 2)});
         target = words_sent + 100;
         while (words_sent < target) send_fragment();
      end
   endtask

   // final stretch with no idling on either side
   task automatic test_quiet_tail();
      int target;
      settle();
      send_idle = 1'b0;
      stall_en  = 1'b0;
      target    = words_sent + 100;
      while (words_sent < target) send_fragment();
   endtask

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      rsp_ready  = 1'b0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      send_idle  = 1'b1;
      stall_en   = 1'b1;
      hold_len   = 0;
      fail_count = 0;
      words_sent = 0;
      cross_model = 1'b1;
      clear_lexer();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_cross_line();
      test_long_tokens();
      test_backpressure();
      test_random();
      test_quiet_tail();

      settle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("script_tokenizer_core_tb passed");
      end else begin
         $display("script_tokenizer_core_tb failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("script_tokenizer_core_tb failed");
      $finish;
   end

endmodule

### sim.f
hw/rtl/stk_pkg.sv
hw/rtl/stk_front.sv
hw/rtl/stk_queue.sv
hw/rtl/stk_back.sv
hw/rtl/script_tokenizer_core.sv
hw/rtl/stk_checker.sv
tb/sv/script_tokenizer_core_tb.sv
